@@ rtl/nrpe_pkg.sv @@
// ============================================================================
// nrpe_pkg: shared types and constants for the NMEA RMC position extractor
// Character codes, token numbers, result kinds, payload structs and the
// readout state type.
// ============================================================================
package nrpe_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] COMMA_CODE   = 8'd44;
    localparam logic [7:0] DOT_CODE     = 8'd46;
    localparam logic [7:0] ZERO_CODE    = 8'd0;

    localparam logic [2:0] TOKEN_LAT  = 3'd4;
    localparam logic [2:0] TOKEN_HEMI = 3'd5;
    localparam logic [2:0] TOKEN_LON  = 3'd6;
    localparam logic [2:0] TOKEN_MAX  = 3'd7;

    localparam logic [1:0] KIND_LAT  = 2'd0;
    localparam logic [1:0] KIND_HEMI = 2'd1;
    localparam logic [1:0] KIND_LON  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic [1:0] field_kind;
        logic [7:0] char_code;
        logic       last;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_SHOW
    } t_drain_state;

endpackage

@@ rtl/nrpe_stream_if.sv @@
// ============================================================================
// nrpe_stream_if: valid/ready stream channel
// One transfer happens at a rising edge where valid and ready are both high.
// ============================================================================
interface nrpe_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/nrpe_ram.sv @@
// ============================================================================
// nrpe_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module nrpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 76
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/nmea_rmc_position_extractor.sv @@
// ============================================================================
// nmea_rmc_position_extractor: latitude/hemisphere/longitude field extractor
// Splits received NMEA lines on commas and returns the stored position
// characters on every newline.
// ============================================================================
// Usage: feed received serial bytes on i_rx, one per transfer. Each line is
// split into tokens on commas (runs of commas count as one separator); the
// byte just before the newline is dropped, a zero byte ends the line's
// content, and a line that reaches LINE_BYTES bytes without a newline
// restarts. Tokens 4, 5 and 6 (latitude, hemisphere letter, longitude) are
// captured, truncated to FIELD_CHARS characters (one for the hemisphere).
// On a newline, freshly captured fields are committed (latitude and
// longitude get their first dot moved two places left when it sits at
// position 2 or later) and every stored character is sent on o_res in the
// order latitude, hemisphere, longitude, with last set on the final one; a
// single result of kind 3 comes out when nothing is stored yet. Timing: a
// non-newline byte never holds off input, so bytes may arrive back to back.
// A newline holds off input until its last result is taken; there are at
// most 2*FIELD_CHARS+1 results. A start state picks the first field, the
// character store is one RAM with a registered read, and each result passes
// through a read state and then the output register. Latitude and
// longitude each own two banks in the RAM; capture writes the idle bank and
// a commit just swaps banks, and the dot fix is applied on readout by
// remapping the read address, so the stored text is never rewritten.
// ============================================================================
module nmea_rmc_position_extractor #(
    parameter int FIELD_CHARS = 19,
    parameter int LINE_BYTES  = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nrpe_stream_if.sink   i_rx,
    nrpe_stream_if.source o_res
);
    import nrpe_pkg::*;

    localparam int LEN_W  = $clog2(FIELD_CHARS + 1);
    localparam int POS_W  = $clog2(LINE_BYTES);
    localparam int DEPTH  = 4 * FIELD_CHARS;
    localparam int ADDR_W = $clog2(DEPTH);

    // RAM slot base: {is_lon, bank} selects one of four FIELD_CHARS regions.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic is_lon, input logic bank,
                                                    input logic [LEN_W-1:0] idx);
        logic [1:0] slot;
        slot = {is_lon, bank};
        return ADDR_W'(slot) * ADDR_W'(FIELD_CHARS) + ADDR_W'(idx);
    endfunction

    // ---------------------------------------------------------------- state
    t_drain_state r_state, n_state;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_held_char, n_held_char;
    logic             r_held_valid, n_held_valid;
    logic             r_ended, n_ended;
    logic [2:0]       r_tok, n_tok;
    logic             r_inside, n_inside;

    // work side (field being captured on the current line)
    logic [LEN_W-1:0] r_lat_len, n_lat_len;
    logic             r_lat_fresh, n_lat_fresh;
    logic [LEN_W-1:0] r_lat_dot, n_lat_dot;
    logic             r_lat_dot_seen, n_lat_dot_seen;
    logic [LEN_W-1:0] r_lon_len, n_lon_len;
    logic             r_lon_fresh, n_lon_fresh;
    logic [LEN_W-1:0] r_lon_dot, n_lon_dot;
    logic             r_lon_dot_seen, n_lon_dot_seen;
    logic [7:0]       r_hemi_work, n_hemi_work;
    logic             r_hemi_fresh, n_hemi_fresh;

    // stored side (last committed fields)
    logic             r_lat_bank, n_lat_bank;
    logic [LEN_W-1:0] r_lat_slen, n_lat_slen;
    logic             r_lat_fix, n_lat_fix;
    logic [LEN_W-1:0] r_lat_sdot, n_lat_sdot;
    logic             r_lon_bank, n_lon_bank;
    logic [LEN_W-1:0] r_lon_slen, n_lon_slen;
    logic             r_lon_fix, n_lon_fix;
    logic [LEN_W-1:0] r_lon_sdot, n_lon_sdot;
    logic [7:0]       r_hemi_store, n_hemi_store;
    logic             r_hemi_slen, n_hemi_slen;

    // readout position and output register
    logic [1:0]       r_kind, n_kind;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [1:0]       r_out_kind, n_out_kind;
    logic [7:0]       r_out_char, n_out_char;
    logic             r_out_last, n_out_last;
    logic             r_out_ram, n_out_ram;

    // RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic       rx_fire;
    logic       res_fire;
    logic [7:0] rx_byte;

    assign rx_byte  = i_rx.payload.rx_byte;
    assign rx_fire  = i_rx.valid && i_rx.ready;
    assign res_fire = o_res.valid && o_res.ready;

    nrpe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_held_char),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------ line capture
    // Tokenize the held byte when the next byte arrives, so the byte right
    // before the newline is never tokenized.
    always_comb begin
        logic             starting;
        logic [LEN_W-1:0] base_len;
        n_pos          = r_pos;
        n_held_char    = r_held_char;
        n_held_valid   = r_held_valid;
        n_ended        = r_ended;
        n_tok          = r_tok;
        n_inside       = r_inside;
        n_lat_len      = r_lat_len;
        n_lat_fresh    = r_lat_fresh;
        n_lat_dot      = r_lat_dot;
        n_lat_dot_seen = r_lat_dot_seen;
        n_lon_len      = r_lon_len;
        n_lon_fresh    = r_lon_fresh;
        n_lon_dot      = r_lon_dot;
        n_lon_dot_seen = r_lon_dot_seen;
        n_hemi_work    = r_hemi_work;
        n_hemi_fresh   = r_hemi_fresh;
        n_lat_bank     = r_lat_bank;
        n_lat_slen     = r_lat_slen;
        n_lat_fix      = r_lat_fix;
        n_lat_sdot     = r_lat_sdot;
        n_lon_bank     = r_lon_bank;
        n_lon_slen     = r_lon_slen;
        n_lon_fix      = r_lon_fix;
        n_lon_sdot     = r_lon_sdot;
        n_hemi_store   = r_hemi_store;
        n_hemi_slen    = r_hemi_slen;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        starting       = 1'b0;
        base_len       = '0;

        if (rx_fire) begin
            if (rx_byte != NEWLINE_CODE) begin
                if (!r_ended) begin
                    if (rx_byte == ZERO_CODE) begin
                        // drop the held byte and ignore the rest of the line
                        n_held_valid = 1'b0;
                        n_ended      = 1'b1;
                    end else begin
                        if (r_held_valid) begin
                            if (r_held_char == COMMA_CODE) begin
                                n_inside = 1'b0;
                            end else begin
                                starting = !r_inside;
                                n_inside = 1'b1;
                                if (starting && r_tok != TOKEN_MAX) begin
                                    n_tok = r_tok + 3'd1;
                                end
                                if (n_tok == TOKEN_LAT) begin
                                    base_len = starting ? '0 : r_lat_len;
                                    if (starting) begin
                                        n_lat_len      = '0;
                                        n_lat_fresh    = 1'b1;
                                        n_lat_dot_seen = 1'b0;
                                    end
                                    if (base_len < LEN_W'(FIELD_CHARS)) begin
                                        ram_we    = 1'b1;
                                        ram_waddr = slot_addr(1'b0, ~r_lat_bank, base_len);
                                        n_lat_len = base_len + LEN_W'(1);
                                        if (r_held_char == DOT_CODE &&
                                            (starting || !r_lat_dot_seen)) begin
                                            n_lat_dot_seen = 1'b1;
                                            n_lat_dot      = base_len;
                                        end
                                    end
                                end else if (n_tok == TOKEN_HEMI) begin
                                    if (starting) begin
                                        n_hemi_work  = r_held_char;
                                        n_hemi_fresh = 1'b1;
                                    end
                                end else if (n_tok == TOKEN_LON) begin
                                    base_len = starting ? '0 : r_lon_len;
                                    if (starting) begin
                                        n_lon_len      = '0;
                                        n_lon_fresh    = 1'b1;
                                        n_lon_dot_seen = 1'b0;
                                    end
                                    if (base_len < LEN_W'(FIELD_CHARS)) begin
                                        ram_we    = 1'b1;
                                        ram_waddr = slot_addr(1'b1, ~r_lon_bank, base_len);
                                        n_lon_len = base_len + LEN_W'(1);
                                        if (r_held_char == DOT_CODE &&
                                            (starting || !r_lon_dot_seen)) begin
                                            n_lon_dot_seen = 1'b1;
                                            n_lon_dot      = base_len;
                                        end
                                    end
                                end
                            end
                        end
                        n_held_char  = rx_byte;
                        n_held_valid = 1'b1;
                    end
                end
                // line wrap: restart the line, keep the stores
                if (r_pos == POS_W'(LINE_BYTES - 1)) begin
                    n_pos        = '0;
                    n_held_valid = 1'b0;
                    n_ended      = 1'b0;
                    n_tok        = '0;
                    n_inside     = 1'b0;
                    n_lat_len    = '0;
                    n_lat_fresh  = 1'b0;
                    n_lon_len    = '0;
                    n_lon_fresh  = 1'b0;
                    n_hemi_fresh = 1'b0;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end else begin
                // newline: commit fresh fields by swapping banks
                if (r_lat_fresh) begin
                    n_lat_bank = ~r_lat_bank;
                    n_lat_slen = r_lat_len;
                    n_lat_fix  = r_lat_dot_seen && (r_lat_dot >= LEN_W'(2));
                    n_lat_sdot = r_lat_dot;
                end
                if (r_hemi_fresh) begin
                    n_hemi_store = r_hemi_work;
                    n_hemi_slen  = 1'b1;
                end
                if (r_lon_fresh) begin
                    n_lon_bank = ~r_lon_bank;
                    n_lon_slen = r_lon_len;
                    n_lon_fix  = r_lon_dot_seen && (r_lon_dot >= LEN_W'(2));
                    n_lon_sdot = r_lon_dot;
                end
                n_pos        = '0;
                n_held_valid = 1'b0;
                n_ended      = 1'b0;
                n_tok        = '0;
                n_inside     = 1'b0;
                n_lat_len    = '0;
                n_lat_fresh  = 1'b0;
                n_lon_len    = '0;
                n_lon_fresh  = 1'b0;
                n_hemi_fresh = 1'b0;
            end
        end
    end

    // ------------------------------------------------------ readout walk
    // First position and the position after (r_kind, r_idx), in the order
    // latitude, hemisphere, longitude.
    logic [1:0]       first_kind, next_kind;
    logic             next_has;
    logic [LEN_W-1:0] next_idx;

    always_comb begin
        if (r_lat_slen != '0) begin
            first_kind = KIND_LAT;
        end else if (r_hemi_slen) begin
            first_kind = KIND_HEMI;
        end else if (r_lon_slen != '0) begin
            first_kind = KIND_LON;
        end else begin
            first_kind = KIND_NONE;
        end
    end

    always_comb begin
        logic after_lat;
        logic after_hemi;
        next_has   = 1'b0;
        next_kind  = KIND_NONE;
        next_idx   = '0;
        after_lat  = 1'b0;
        after_hemi = 1'b0;
        case (r_kind)
            KIND_LAT: begin
                if (r_idx + LEN_W'(1) < r_lat_slen) begin
                    next_has  = 1'b1;
                    next_kind = KIND_LAT;
                    next_idx  = r_idx + LEN_W'(1);
                end else begin
                    after_lat = 1'b1;
                end
            end
            KIND_HEMI: after_hemi = 1'b1;
            KIND_LON: begin
                if (r_idx + LEN_W'(1) < r_lon_slen) begin
                    next_has  = 1'b1;
                    next_kind = KIND_LON;
                    next_idx  = r_idx + LEN_W'(1);
                end
            end
            default: next_has = 1'b0;
        endcase
        if (after_lat && r_hemi_slen) begin
            next_has  = 1'b1;
            next_kind = KIND_HEMI;
        end else if ((after_lat || after_hemi) && r_lon_slen != '0) begin
            next_has  = 1'b1;
            next_kind = KIND_LON;
        end
    end

    // read address with the dot fix folded in: at the dot's new place emit
    // a dot, the next two places read one position back
    logic             cur_fix;
    logic [LEN_W-1:0] cur_sdot;
    logic [LEN_W-1:0] rd_idx;
    logic             emit_dot;

    always_comb begin
        cur_fix  = (r_kind == KIND_LON) ? r_lon_fix : r_lat_fix;
        cur_sdot = (r_kind == KIND_LON) ? r_lon_sdot : r_lat_sdot;
        rd_idx   = r_idx;
        emit_dot = cur_fix && (r_idx + LEN_W'(2) == cur_sdot);
        if (cur_fix && (r_idx == cur_sdot || r_idx + LEN_W'(1) == cur_sdot)) begin
            rd_idx = r_idx - LEN_W'(1);
        end
        ram_raddr = slot_addr(r_kind == KIND_LON,
                              (r_kind == KIND_LON) ? r_lon_bank : r_lat_bank, rd_idx);
    end

    // ------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (rx_fire && rx_byte == NEWLINE_CODE) begin
                    n_state = ST_START;
                end
            end
            ST_START: n_state = ST_READ;
            ST_READ:  n_state = ST_SHOW;
            ST_SHOW: begin
                if (res_fire) begin
                    n_state = r_out_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------ outputs
    always_comb begin
        i_rx.ready  = (r_state == ST_IDLE);
        o_res.valid = (r_state == ST_SHOW);
        ram_re      = (r_state == ST_READ) && (r_kind == KIND_LAT || r_kind == KIND_LON)
                      && !emit_dot;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_out_kind  = r_out_kind;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_ram   = r_out_ram;
        unique case (r_state)
            ST_START: begin
                n_kind = first_kind;
                n_idx  = '0;
            end
            ST_READ: begin
                n_out_kind = r_kind;
                n_out_last = !next_has;
                case (r_kind)
                    KIND_HEMI: begin
                        n_out_ram  = 1'b0;
                        n_out_char = r_hemi_store;
                    end
                    KIND_NONE: begin
                        n_out_ram  = 1'b0;
                        n_out_char = ZERO_CODE;
                    end
                    default: begin
                        n_out_ram  = !emit_dot;
                        n_out_char = DOT_CODE;
                    end
                endcase
            end
            ST_SHOW: begin
                if (res_fire) begin
                    n_kind = next_kind;
                    n_idx  = next_idx;
                end
            end
            default: n_kind = r_kind;
        endcase
    end

    assign o_res.payload.field_kind = r_out_kind;
    assign o_res.payload.char_code  = r_out_ram ? ram_rdata : r_out_char;
    assign o_res.payload.last       = r_out_last;

    // ------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_pos          <= '0;
            r_held_valid   <= 1'b0;
            r_ended        <= 1'b0;
            r_tok          <= '0;
            r_inside       <= 1'b0;
            r_lat_len      <= '0;
            r_lat_fresh    <= 1'b0;
            r_lat_dot_seen <= 1'b0;
            r_lon_len      <= '0;
            r_lon_fresh    <= 1'b0;
            r_lon_dot_seen <= 1'b0;
            r_hemi_fresh   <= 1'b0;
            r_lat_bank     <= 1'b0;
            r_lat_slen     <= '0;
            r_lat_fix      <= 1'b0;
            r_lon_bank     <= 1'b0;
            r_lon_slen     <= '0;
            r_lon_fix      <= 1'b0;
            r_hemi_slen    <= 1'b0;
            r_kind         <= KIND_NONE;
            r_idx          <= '0;
            r_out_last     <= 1'b0;
            r_out_ram      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pos          <= n_pos;
            r_held_valid   <= n_held_valid;
            r_ended        <= n_ended;
            r_tok          <= n_tok;
            r_inside       <= n_inside;
            r_lat_len      <= n_lat_len;
            r_lat_fresh    <= n_lat_fresh;
            r_lat_dot_seen <= n_lat_dot_seen;
            r_lon_len      <= n_lon_len;
            r_lon_fresh    <= n_lon_fresh;
            r_lon_dot_seen <= n_lon_dot_seen;
            r_hemi_fresh   <= n_hemi_fresh;
            r_lat_bank     <= n_lat_bank;
            r_lat_slen     <= n_lat_slen;
            r_lat_fix      <= n_lat_fix;
            r_lon_bank     <= n_lon_bank;
            r_lon_slen     <= n_lon_slen;
            r_lon_fix      <= n_lon_fix;
            r_hemi_slen    <= n_hemi_slen;
            r_kind         <= n_kind;
            r_idx          <= n_idx;
            r_out_last     <= n_out_last;
            r_out_ram      <= n_out_ram;
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_held_char  <= n_held_char;
        r_lat_dot    <= n_lat_dot;
        r_lon_dot    <= n_lon_dot;
        r_hemi_work  <= n_hemi_work;
        r_lat_sdot   <= n_lat_sdot;
        r_lon_sdot   <= n_lon_sdot;
        r_hemi_store <= n_hemi_store;
        r_out_kind   <= n_out_kind;
        r_out_char   <= n_out_char;
    end

endmodule

@@ dv/tb_nmea_rmc_position_extractor.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_nmea_rmc_position_extractor: self-checking bench for the RMC extractor
// Streams NMEA-like lines into the block and scores every result against a
// local prediction of the latitude, hemisphere and longitude stores. Both
// handshake sides idle at random in phases; a watchdog guards against hangs.
// ============================================================================
module tb_nmea_rmc_position_extractor;

    import nrpe_pkg::*;

    localparam int FIELD_CHARS  = 19;
    localparam int LINE_BYTES   = 128;
    localparam int TARGET_BYTES = 430;
    // a newline drains at most 2*FIELD_CHARS+1 results
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    localparam logic [7:0] CR_CODE = 8'd13;

    // slots of the coordinate arrays
    localparam int LAT = 0;
    localparam int LON = 1;

    logic i_clk;
    logic i_rst_n;

    nrpe_stream_if #(.t_payload(t_rx_item)) rx_ch ();
    nrpe_stream_if #(.t_payload(t_result))  res_ch ();

    nmea_rmc_position_extractor #(
        .FIELD_CHARS (FIELD_CHARS),
        .LINE_BYTES  (LINE_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch.sink),
        .o_res   (res_ch.source)
    );

    // ------------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------------
    logic [7:0] rx_bytes_pending [$];
    t_result    expected_chars [$];
    int         rx_total;
    int         rx_accepted;
    int         mismatches;
    int         quiet_cycles;

    // ------------------------------------------------------------------------
    // Predicted line parser and field stores
    // ------------------------------------------------------------------------
    int         line_pos;
    logic [7:0] held_char;
    bit         held_valid;
    bit         line_dead;      // zero byte seen, rest of line ignored
    logic [2:0] tok_num;
    bit         in_tok;

    logic [7:0] coord_work [2][FIELD_CHARS];
    int         coord_work_len [2];
    bit         coord_work_fresh [2];
    logic [7:0] coord_store [2][FIELD_CHARS];
    int         coord_store_len [2];

    logic [7:0] hemi_work;
    bit         hemi_work_fresh;
    logic [7:0] hemi_store;
    bit         hemi_store_valid;

    // Drop the held byte, the token count and any fresh work fields; the
    // committed stores survive.
    function automatic void restart_line();
        line_pos                 = 0;
        held_char                = ZERO_CODE;
        held_valid               = 1'b0;
        line_dead                = 1'b0;
        tok_num                  = 3'd0;
        in_tok                   = 1'b0;
        coord_work_len[LAT]      = 0;
        coord_work_len[LON]      = 0;
        coord_work_fresh[LAT]    = 1'b0;
        coord_work_fresh[LON]    = 1'b0;
        hemi_work_fresh          = 1'b0;
    endfunction

    function automatic void clear_parser();
        restart_line();
        hemi_work          = ZERO_CODE;
        hemi_store         = ZERO_CODE;
        hemi_store_valid   = 1'b0;
        coord_store_len[LAT] = 0;
        coord_store_len[LON] = 0;
    endfunction

    // Feed one content character to the comma splitter. Comma runs collapse,
    // so a comma only closes the current token.
    function automatic void split_on_commas(logic [7:0] c);
        bit starting;
        int slot;
        if (c == COMMA_CODE) begin
            in_tok = 1'b0;
            return;
        end
        starting = !in_tok;
        if (starting) begin
            in_tok = 1'b1;
            if (tok_num < TOKEN_MAX) begin
                tok_num = tok_num + 3'd1;
            end
        end
        if (tok_num == TOKEN_HEMI) begin
            // only the first letter of the hemisphere token counts
            if (starting) begin
                hemi_work       = c;
                hemi_work_fresh = 1'b1;
            end
        end else if (tok_num == TOKEN_LAT || tok_num == TOKEN_LON) begin
            slot = (tok_num == TOKEN_LAT) ? LAT : LON;
            if (starting) begin
                coord_work_len[slot]   = 0;
                coord_work_fresh[slot] = 1'b1;
            end
            // truncate to the field size
            if (coord_work_len[slot] < FIELD_CHARS) begin
                coord_work[slot][coord_work_len[slot]] = c;
                coord_work_len[slot] = coord_work_len[slot] + 1;
            end
        end
    endfunction

    // Commit a fresh coordinate; the first dot moves two places left unless
    // it already sits at position 0 or 1.
    function automatic void commit_coord(int slot);
        int i;
        int dot_at;
        dot_at = -1;
        for (i = 0; i < coord_work_len[slot]; i++) begin
            if (dot_at < 0 && coord_work[slot][i] == DOT_CODE) begin
                dot_at = i;
            end
        end
        for (i = 0; i < FIELD_CHARS; i++) begin
            coord_store[slot][i] = coord_work[slot][i];
        end
        if (dot_at >= 2) begin
            coord_store[slot][dot_at]     = coord_work[slot][dot_at - 1];
            coord_store[slot][dot_at - 1] = coord_work[slot][dot_at - 2];
            coord_store[slot][dot_at - 2] = DOT_CODE;
        end
        coord_store_len[slot] = coord_work_len[slot];
    endfunction

    function automatic void expect_char(logic [1:0] kind, logic [7:0] c);
        t_result r;
        r.field_kind = kind;
        r.char_code  = c;
        r.last       = 1'b0;
        expected_chars.push_back(r);
    endfunction

    // Advance the prediction by one accepted byte and queue what a newline
    // brings out.
    function automatic void predict_rx_byte(logic [7:0] c);
        int i;
        int first;
        if (c != NEWLINE_CODE) begin
            if (!line_dead) begin
                if (c == ZERO_CODE) begin
                    held_valid = 1'b0;
                    line_dead  = 1'b1;
                end else begin
                    // the previous byte is only used once a successor arrives
                    if (held_valid) begin
                        split_on_commas(held_char);
                    end
                    held_char  = c;
                    held_valid = 1'b1;
                end
            end
            line_pos = line_pos + 1;
            if (line_pos >= LINE_BYTES) begin
                restart_line();
            end
            return;
        end

        // newline: the held byte is dropped, fresh fields are committed
        if (coord_work_fresh[LAT]) begin
            commit_coord(LAT);
        end
        if (hemi_work_fresh) begin
            hemi_store       = hemi_work;
            hemi_store_valid = 1'b1;
        end
        if (coord_work_fresh[LON]) begin
            commit_coord(LON);
        end
        restart_line();

        first = expected_chars.size();
        for (i = 0; i < coord_store_len[LAT]; i++) begin
            expect_char(KIND_LAT, coord_store[LAT][i]);
        end
        if (hemi_store_valid) begin
            expect_char(KIND_HEMI, hemi_store);
        end
        for (i = 0; i < coord_store_len[LON]; i++) begin
            expect_char(KIND_LON, coord_store[LON][i]);
        end
        if (expected_chars.size() == first) begin
            expect_char(KIND_NONE, ZERO_CODE);
        end
        expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Line generators
    // ------------------------------------------------------------------------
    function automatic void push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            rx_bytes_pending.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] v;
        v = NEWLINE_CODE;
        while (v == NEWLINE_CODE) begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'd48 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] letter_char();
        return 8'd65 + 8'($urandom_range(0, 25));
    endfunction

    // Separator: mostly one comma, sometimes a run that collapses to one.
    function automatic void push_sep(ref logic [7:0] s [$]);
        int n;
        int i;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : 1;
        for (i = 0; i < n; i++) begin
            s.push_back(COMMA_CODE);
        end
    endfunction

    // Coordinate token: mostly short, sometimes empty or near or past the field size,
    // with the dot anywhere (also first, second or absent).
    function automatic void push_coord(ref logic [7:0] s [$]);
        int len;
        int dot_at;
        int pick;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            len = 0;
        end else if (pick < 85) begin
            len = $urandom_range(1, 11);
        end else begin
            len = $urandom_range(FIELD_CHARS - 2, FIELD_CHARS + 6);
        end
        dot_at = ($urandom_range(0, 9) < 8) ? $urandom_range(0, len) : -1;
        for (i = 0; i < len; i++) begin
            if (i == dot_at || $urandom_range(0, 24) == 0) begin
                s.push_back(DOT_CODE);
            end else if ($urandom_range(0, 29) == 0) begin
                s.push_back(8'd128 + 8'($urandom_range(0, 127)));
            end else begin
                s.push_back(digit_char());
            end
        end
    endfunction

    // One RMC-like sentence; a broken one gets a zero byte, a stray newline
    // or loses its tail.
    function automatic void push_sentence(bit broken);
        logic [7:0] s [$];
        string      hemis;
        int         i;
        int         n;
        int         cut;
        hemis = "NSEW";
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
            s.push_back(letter_char());
        end
        push_sep(s);
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            s.push_back(digit_char());
        end
        push_sep(s);
        s.push_back(($urandom_range(0, 1) == 0) ? 8'd65 : 8'd86);
        push_sep(s);
        push_coord(s);
        push_sep(s);
        n = $urandom_range(0, 99);
        if (n < 85) begin
            s.push_back(hemis[$urandom_range(0, 3)]);
        end else if (n < 93) begin
            s.push_back(hemis[$urandom_range(0, 3)]);
            s.push_back(letter_char());
        end
        push_sep(s);
        push_coord(s);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
            push_sep(s);
            s.push_back(letter_char());
        end
        n = $urandom_range(0, 19);
        if (n < 17) begin
            s.push_back(CR_CODE);
        end else if (n == 17) begin
            s.push_back(COMMA_CODE);
        end
        s.push_back(NEWLINE_CODE);

        if (broken) begin
            cut = $urandom_range(0, s.size() - 1);
            case ($urandom_range(0, 2))
                0: begin
                    s.insert(cut, ZERO_CODE);
                end
                1: begin
                    s.insert(cut, NEWLINE_CODE);
                end
                default: begin
                    while (s.size() > cut) begin
                        void'(s.pop_back());
                    end
                end
            endcase
        end
        foreach (s[i]) begin
            rx_bytes_pending.push_back(s[i]);
        end
    endfunction

    // A run of bytes without a newline, often long enough to force the line to restart.
    function automatic void push_wrap_run();
        int n;
        int i;
        n = $urandom_range(LINE_BYTES - 28, LINE_BYTES + 12);
        for (i = 0; i < n; i++) begin
            rx_bytes_pending.push_back(any_but_newline());
        end
    endfunction

    function automatic void push_noise_line();
        int n;
        int i;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
            rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
        end
        rx_bytes_pending.push_back(NEWLINE_CODE);
    endfunction

    // ------------------------------------------------------------------------
    // Idle schedule: sender light / receiver heavy, then the reverse, then
    // full throughput
    // ------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        if (rx_accepted < rx_total / 3) begin
            return 10;
        end else if (rx_accepted < (2 * rx_total) / 3) begin
            return 46;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (rx_accepted < rx_total / 3) begin
            return 46;
        end else if (rx_accepted < (2 * rx_total) / 3) begin
            return 10;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n        = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.payload  = '0;
        res_ch.ready   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Byte driver: score each transfer, then hold or advance valid
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                predict_rx_byte(rx_ch.payload.rx_byte);
                rx_accepted <= rx_accepted + 1;
            end
            if (!rx_ch.valid || rx_ch.ready) begin
                if (rx_bytes_pending.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct()) begin
                    rx_ch.valid           <= 1'b1;
                    rx_ch.payload.rx_byte <= rx_bytes_pending.pop_front();
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("unexpected result: kind %0d char %02h last %0b",
                                 res_ch.payload.field_kind, res_ch.payload.char_code,
                                 res_ch.payload.last);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (res_ch.payload.field_kind != want.field_kind ||
                        res_ch.payload.char_code  != want.char_code  ||
                        res_ch.payload.last       != want.last) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("bad result: got kind %0d char %02h last %0b, %s %0d %02h %0b",
                                     res_ch.payload.field_kind, res_ch.payload.char_code,
                                     res_ch.payload.last, "want",
                                     want.field_kind, want.char_code, want.last);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too long without any transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        rx_accepted  = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        clear_parser();

        // directed: empty line before anything is stored, a sentence with
        // a dot to move, a two-letter hemisphere, a longitude whose dot is
        // first and a token past the sixth, then a zero byte after 0xFF
        push_text("\n");
        push_text("a,b,c,1234.5,NS,.7,z\r\n");
        rx_bytes_pending.push_back(8'hFF);
        rx_bytes_pending.push_back(ZERO_CODE);
        push_text("x\n");

        // a long run without a newline, usually forcing a line restart, before the random part
        push_sentence(1'b0);
        push_wrap_run();
        push_sentence(1'b0);

        while (rx_bytes_pending.size() < TARGET_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                push_sentence(1'b0);
            end else if (pick < 82) begin
                push_sentence(1'b1);
            end else if (pick < 92) begin
                push_noise_line();
            end else if (pick < 97) begin
                rx_bytes_pending.push_back(NEWLINE_CODE);
            end else begin
                push_wrap_run();
                push_sentence(1'b0);
            end
        end
        // close any line left open so every prediction gets drained
        rx_bytes_pending.push_back(NEWLINE_CODE);
        rx_total = rx_bytes_pending.size();

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (rx_bytes_pending.size() != 0 || rx_ch.valid) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        // let any stray results surface
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
